>>> rtl/core/eight_bit_cpu_instruction_step_top_defines.svh
// Assertion macros for the instruction step core.
`ifndef EIGHT_BIT_CPU_INSTRUCTION_STEP_TOP_DEFINES_SVH
`define EIGHT_BIT_CPU_INSTRUCTION_STEP_TOP_DEFINES_SVH

`ifndef SYNTH
`define ECS_ASSERT(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("check failed");
`define ECS_ASSERT_NR(label, clock, prop) \
	label: assert property (@(posedge clock) prop) else $error("check failed");
`else
`define ECS_ASSERT(label, clock, rstn, prop)
`define ECS_ASSERT_NR(label, clock, prop)
`endif

`endif

>>> rtl/core/ecs_pkg.sv
`timescale 1ns / 1ps
package ecs_pkg;

	localparam int unsigned NumRegs = 16;
	localparam logic [1:0] StrobeNone = 2'd0;
	localparam logic [1:0] StrobeOut  = 2'd1;
	localparam logic [1:0] StrobeInp  = 2'd2;
	localparam logic [1:0] CyclesShort = 2'd2;
	localparam logic [1:0] CyclesLong  = 2'd3;

	typedef struct packed {
		logic [7:0] op;
		logic [7:0] imm_first;
		logic [7:0] imm_second;
		logic [7:0] mem_data;
		logic [7:0] port_in;
		logic [3:0] ext_flags;
	} req_t;

	typedef struct packed {
		logic [15:0] data_addr;
		logic        mem_read;
		logic        mem_write;
		logic [7:0]  write_data;
		logic [1:0]  port_strobe;
		logic [2:0]  port_num;
		logic [15:0] next_pc;
		logic [7:0]  acc;
		logic        carry;
		logic        q_flag;
		logic [1:0]  cycles;
		logic        idle;
	} rsp_t;

endpackage

>>> rtl/core/eight_bit_cpu_instruction_step_top.sv
`timescale 1ns / 1ps
// An accepted word passes through the input register, then the result register, to the result word.
// Throughput: one instruction word per cycle; a word waits in the input register
// only while the result register is held by rsp_stall.
// Reset: asynchronous, active low; clears all registers, D, DF, P, X, T, Q, idle,
// sets IE, and empties both pipeline registers.
`include "eight_bit_cpu_instruction_step_top_defines.svh"
module eight_bit_cpu_instruction_step_top
	import ecs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic        v_s1;
	req_t        req_s1;
	logic        adv;
	rsp_t        rsp_q;
	logic        rsp_v_q;

	logic [15:0] rf_q [NumRegs];
	logic [7:0]  d_q, t_q;
	logic        df_q, q_q, ie_q, idle_q;
	logic [3:0]  p_q, x_q;

	assign adv       = v_s1 && (!rsp_v_q || !rsp_stall);
	assign req_stall = v_s1 && !adv;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	logic [3:0]  n;
	logic [15:0] pc, pc1, rn, rx, r2;
	logic [15:0] pc_new, wval;
	logic [3:0]  widx;
	logic        wen;
	logic [7:0]  d_n, t_n;
	logic        df_n, q_n, ie_n, idle_n;
	logic [3:0]  p_n, x_n;
	logic        cond, br, sk, use_add;
	logic [7:0]  aa, ab;
	logic        ac;
	logic [8:0]  sum;
	rsp_t        res;
	logic [7:0]  m, i1;

	always_comb begin
		n   = req_s1.op[3:0];
		m   = req_s1.mem_data;
		i1  = req_s1.imm_first;
		pc  = rf_q[p_q];
		pc1 = pc + 16'd1;
		rn  = (n == p_q) ? pc1 : rf_q[n];
		rx  = (x_q == p_q) ? pc1 : rf_q[x_q];
		r2  = (p_q == 4'd2) ? pc1 : rf_q[2];
		pc_new = pc1;
		wen  = 1'b0;
		widx = n;
		wval = rn;
		d_n = d_q; df_n = df_q; t_n = t_q; q_n = q_q; ie_n = ie_q; idle_n = idle_q;
		p_n = p_q; x_n = x_q;
		use_add = 1'b0; aa = d_q; ab = m; ac = df_q;
		cond = 1'b0; br = 1'b0; sk = 1'b0;
		res = '0;
		res.cycles = CyclesShort;

		case (req_s1.op[7:4])
			4'h0: begin
				if (n == 4'd0) begin
					idle_n = 1'b1;
				end else begin
					res.data_addr = rn; res.mem_read = 1'b1; d_n = m;
				end
			end
			4'h1: begin wen = 1'b1; wval = rn + 16'd1; end
			4'h2: begin wen = 1'b1; wval = rn - 16'd1; end
			4'h3: begin
				case (n[2:0])
					3'd0: cond = 1'b1;
					3'd1: cond = q_q;
					3'd2: cond = (d_q == 8'd0);
					3'd3: cond = df_q;
					default: cond = req_s1.ext_flags[n[1:0]];
				endcase
				if (n[3]) cond = !cond;
				pc_new = cond ? {pc1[15:8], i1} : pc1 + 16'd1;
			end
			4'h4: begin
				res.data_addr = rn; res.mem_read = 1'b1; d_n = m;
				wen = 1'b1; wval = rn + 16'd1;
			end
			4'h5: begin
				res.data_addr = rn; res.mem_write = 1'b1; res.write_data = d_q;
			end
			4'h6: begin
				widx = x_q;
				if (n == 4'd0) begin
					wen = 1'b1; wval = rx + 16'd1;
				end else if (!n[3]) begin
					res.data_addr = rx; res.mem_read = 1'b1;
					res.port_strobe = StrobeOut; res.port_num = n[2:0];
					wen = 1'b1; wval = rx + 16'd1;
				end else if (n != 4'd8) begin
					res.data_addr = rx; res.mem_write = 1'b1;
					res.write_data = req_s1.port_in; d_n = req_s1.port_in;
					res.port_strobe = StrobeInp; res.port_num = n[2:0];
				end
			end
			4'h7: begin
				widx = x_q;
				case (n)
					4'h0, 4'h1: begin
						res.data_addr = rx; res.mem_read = 1'b1;
						x_n = m[7:4]; p_n = m[3:0];
						wen = 1'b1; wval = rx + 16'd1;
						ie_n = (n == 4'h0);
					end
					4'h2: begin
						res.data_addr = rx; res.mem_read = 1'b1; d_n = m;
						wen = 1'b1; wval = rx + 16'd1;
					end
					4'h3: begin
						res.data_addr = rx; res.mem_write = 1'b1; res.write_data = d_q;
						wen = 1'b1; wval = rx - 16'd1;
					end
					4'h4: begin
						res.data_addr = rx; res.mem_read = 1'b1;
						use_add = 1'b1; aa = d_q; ab = m;
					end
					4'h5: begin
						res.data_addr = rx; res.mem_read = 1'b1;
						use_add = 1'b1; aa = m; ab = ~d_q;
					end
					4'h6: begin df_n = d_q[0]; d_n = {df_q, d_q[7:1]}; end
					4'h7: begin
						res.data_addr = rx; res.mem_read = 1'b1;
						use_add = 1'b1; aa = d_q; ab = ~m;
					end
					4'h8: begin
						res.data_addr = rx; res.mem_write = 1'b1; res.write_data = t_q;
					end
					4'h9: begin
						t_n = {x_q, p_q};
						res.data_addr = r2; res.mem_write = 1'b1; res.write_data = {x_q, p_q};
						x_n = p_q;
						widx = 4'd2; wen = 1'b1; wval = r2 - 16'd1;
					end
					4'hA: q_n = 1'b0;
					4'hB: q_n = 1'b1;
					4'hC: begin use_add = 1'b1; aa = d_q; ab = i1; pc_new = pc1 + 16'd1; end
					4'hD: begin use_add = 1'b1; aa = i1; ab = ~d_q; pc_new = pc1 + 16'd1; end
					4'hE: begin df_n = d_q[7]; d_n = {d_q[6:0], df_q}; end
					default: begin
						use_add = 1'b1; aa = d_q; ab = ~i1; pc_new = pc1 + 16'd1;
					end
				endcase
			end
			4'h8: d_n = rn[7:0];
			4'h9: d_n = rn[15:8];
			4'hA: begin wen = 1'b1; wval = {rn[15:8], d_q}; end
			4'hB: begin wen = 1'b1; wval = {d_q, rn[7:0]}; end
			4'hC: begin
				res.cycles = CyclesLong;
				case (n)
					4'h0: begin br = 1'b1; cond = 1'b1; end
					4'h1: begin br = 1'b1; cond = q_q; end
					4'h2: begin br = 1'b1; cond = (d_q == 8'd0); end
					4'h3: begin br = 1'b1; cond = df_q; end
					4'h4: sk = 1'b0;
					4'h5: sk = !q_q;
					4'h6: sk = (d_q != 8'd0);
					4'h7: sk = !df_q;
					4'h8: sk = 1'b1;
					4'h9: begin br = 1'b1; cond = !q_q; end
					4'hA: begin br = 1'b1; cond = (d_q != 8'd0); end
					4'hB: begin br = 1'b1; cond = !df_q; end
					4'hC: sk = ie_q;
					4'hD: sk = q_q;
					4'hE: sk = (d_q == 8'd0);
					default: sk = df_q;
				endcase
				if (br && cond) begin
					pc_new = {i1, req_s1.imm_second};
				end else if (br || sk) begin
					pc_new = pc1 + 16'd2;
				end
			end
			4'hD: p_n = n;
			4'hE: x_n = n;
			default: begin
				if (!n[3]) begin
					if (n != 4'd6) begin
						res.data_addr = rx; res.mem_read = 1'b1;
					end
					case (n[2:0])
						3'd0: d_n = m;
						3'd1: d_n = d_q | m;
						3'd2: d_n = d_q & m;
						3'd3: d_n = d_q ^ m;
						3'd4: begin use_add = 1'b1; aa = d_q; ab = m; ac = 1'b0; end
						3'd5: begin use_add = 1'b1; aa = m; ab = ~d_q; ac = 1'b1; end
						3'd6: begin df_n = d_q[0]; d_n = {1'b0, d_q[7:1]}; end
						default: begin use_add = 1'b1; aa = d_q; ab = ~m; ac = 1'b1; end
					endcase
				end else begin
					if (n != 4'hE) pc_new = pc1 + 16'd1;
					case (n[2:0])
						3'd0: d_n = i1;
						3'd1: d_n = d_q | i1;
						3'd2: d_n = d_q & i1;
						3'd3: d_n = d_q ^ i1;
						3'd4: begin use_add = 1'b1; aa = d_q; ab = i1; ac = 1'b0; end
						3'd5: begin use_add = 1'b1; aa = i1; ab = ~d_q; ac = 1'b1; end
						3'd6: begin df_n = d_q[7]; d_n = {d_q[6:0], 1'b0}; end
						default: begin use_add = 1'b1; aa = d_q; ab = ~i1; ac = 1'b1; end
					endcase
				end
			end
		endcase

		sum = {1'b0, aa} + {1'b0, ab} + {8'd0, ac};
		if (use_add) begin
			d_n = sum[7:0]; df_n = sum[8];
		end

		if (idle_q) begin
			res = '0;
			res.cycles = CyclesShort;
			wen = 1'b0;
			pc_new = pc;
			d_n = d_q; df_n = df_q; t_n = t_q; q_n = q_q; ie_n = ie_q; idle_n = 1'b1;
			p_n = p_q; x_n = x_q;
		end

		if (wen && widx == p_n) begin
			res.next_pc = wval;
		end else if (p_n == p_q) begin
			res.next_pc = pc_new;
		end else begin
			res.next_pc = rf_q[p_n];
		end
		res.acc    = d_n;
		res.carry  = df_n;
		res.q_flag = q_n;
		res.idle   = idle_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
			d_q <= '0; df_q <= 1'b0; t_q <= '0; q_q <= 1'b0; ie_q <= 1'b1;
			idle_q <= 1'b0; p_q <= '0; x_q <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			if (adv) begin
				if (!wen || widx != p_q) rf_q[p_q] <= pc_new;
				if (wen) rf_q[widx] <= wval;
				d_q <= d_n; df_q <= df_n; t_q <= t_n; q_q <= q_n; ie_q <= ie_n;
				idle_q <= idle_n; p_q <= p_n; x_q <= x_n;
				rsp_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) rsp_q <= res;
	end

	`ECS_ASSERT(a_idle_sticky, clk, arst_n, idle_q |=> idle_q)
	`ECS_ASSERT(a_idle_quiet, clk, arst_n, (adv && idle_q) |=> (!rsp_q.mem_write && !rsp_q.mem_read))
	`ECS_ASSERT(a_no_stall_empty, clk, arst_n, !v_s1 |-> !req_stall)
	`ECS_ASSERT(a_held_result, clk, arst_n, (rsp_v_q && rsp_stall) |=> (rsp_v_q && $stable(rsp_q)))

endmodule

>>> bench/tb_eight_bit_cpu_instruction_step_top.sv
`timescale 1ns / 1ps
module tb_eight_bit_cpu_instruction_step_top;
	import ecs_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	eight_bit_cpu_instruction_step_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	localparam int WatchdogLimit = 5000;
	localparam logic [7:0] OpIdle = 8'h00;

	// core shadow state
	logic [15:0] regs [16];
	logic [7:0] d_acc;
	logic df;
	logic [3:0] psel;
	logic [3:0] xsel;
	logic [7:0] t_reg;
	logic q_reg;
	logic ie;
	logic halted;

	rsp_t expected_rsp [$];
	int errors;
	bit no_idle;
	int quiet_cycles;

	typedef struct {
		req_t word;
		bit has_fixed;
		rsp_t fixed;
	} step_row_t;
	step_row_t directed [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_carry(input logic [7:0] a, input logic [7:0] b, input logic ci);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + {8'd0, ci};
		d_acc = s[7:0];
		df = s[8];
	endfunction

	function automatic rsp_t execute_instruction(input req_t w);
		rsp_t r;
		logic [3:0] n, p, x;
		logic c, branch, skip;
		r = '0;
		r.cycles = CyclesShort;
		n = w.op[3:0];
		p = psel;
		x = xsel;
		c = 1'b0;
		branch = 1'b0;
		skip = 1'b0;
		if (!halted) begin
			regs[p] = regs[p] + 16'd1;
			case (w.op[7:4])
				4'h0: begin
					if (n == 0) halted = 1'b1;
					else begin
						r.data_addr = regs[n]; r.mem_read = 1; d_acc = w.mem_data;
					end
				end
				4'h1: regs[n] = regs[n] + 16'd1;
				4'h2: regs[n] = regs[n] - 16'd1;
				4'h3: begin
					case (n[2:0])
						3'd0: c = 1'b1;
						3'd1: c = q_reg;
						3'd2: c = (d_acc == 0);
						3'd3: c = df;
						default: c = w.ext_flags[n[1:0]];
					endcase
					if (n[3]) c = ~c;
					if (c) regs[p][7:0] = w.imm_first;
					else regs[p] = regs[p] + 16'd1;
				end
				4'h4: begin
					r.data_addr = regs[n]; r.mem_read = 1; d_acc = w.mem_data;
					regs[n] = regs[n] + 16'd1;
				end
				4'h5: begin
					r.data_addr = regs[n]; r.mem_write = 1; r.write_data = d_acc;
				end
				4'h6: begin
					if (n == 0) regs[x] = regs[x] + 16'd1;
					else if (n < 8) begin
						r.data_addr = regs[x]; r.mem_read = 1; r.port_strobe = StrobeOut;
						r.port_num = n[2:0]; regs[x] = regs[x] + 16'd1;
					end else if (n > 8) begin
						r.data_addr = regs[x]; r.mem_write = 1; r.write_data = w.port_in;
						d_acc = w.port_in; r.port_strobe = StrobeInp; r.port_num = n[2:0];
					end
				end
				4'h7: begin
					case (n)
						4'h0, 4'h1: begin
							r.data_addr = regs[x]; r.mem_read = 1;
							xsel = w.mem_data[7:4]; psel = w.mem_data[3:0];
							regs[x] = regs[x] + 16'd1;
							ie = (n == 0);
						end
						4'h2: begin
							r.data_addr = regs[x]; r.mem_read = 1; d_acc = w.mem_data;
							regs[x] = regs[x] + 16'd1;
						end
						4'h3: begin
							r.data_addr = regs[x]; r.mem_write = 1; r.write_data = d_acc;
							regs[x] = regs[x] - 16'd1;
						end
						4'h4: begin
							r.data_addr = regs[x]; r.mem_read = 1; add_carry(d_acc, w.mem_data, df);
						end
						4'h5: begin
							r.data_addr = regs[x]; r.mem_read = 1; add_carry(w.mem_data, ~d_acc, df);
						end
						4'h6: begin
							c = df; df = d_acc[0]; d_acc = {c, d_acc[7:1]};
						end
						4'h7: begin
							r.data_addr = regs[x]; r.mem_read = 1; add_carry(d_acc, ~w.mem_data, df);
						end
						4'h8: begin
							r.data_addr = regs[x]; r.mem_write = 1; r.write_data = t_reg;
						end
						4'h9: begin
							t_reg = {x, p};
							r.data_addr = regs[2]; r.mem_write = 1; r.write_data = t_reg;
							xsel = p;
							regs[2] = regs[2] - 16'd1;
						end
						4'hA: q_reg = 1'b0;
						4'hB: q_reg = 1'b1;
						4'hC: begin add_carry(d_acc, w.imm_first, df); regs[p] = regs[p] + 16'd1; end
						4'hD: begin add_carry(w.imm_first, ~d_acc, df); regs[p] = regs[p] + 16'd1; end
						4'hE: begin c = df; df = d_acc[7]; d_acc = {d_acc[6:0], c}; end
						default: begin
							add_carry(d_acc, ~w.imm_first, df); regs[p] = regs[p] + 16'd1;
						end
					endcase
				end
				4'h8: d_acc = regs[n][7:0];
				4'h9: d_acc = regs[n][15:8];
				4'hA: regs[n][7:0] = d_acc;
				4'hB: regs[n][15:8] = d_acc;
				4'hC: begin
					r.cycles = CyclesLong;
					case (n)
						4'h0: begin branch = 1; c = 1; end
						4'h1: begin branch = 1; c = q_reg; end
						4'h2: begin branch = 1; c = (d_acc == 0); end
						4'h3: begin branch = 1; c = df; end
						4'h4: ;
						4'h5: skip = ~q_reg;
						4'h6: skip = (d_acc != 0);
						4'h7: skip = ~df;
						4'h8: skip = 1;
						4'h9: begin branch = 1; c = ~q_reg; end
						4'hA: begin branch = 1; c = (d_acc != 0); end
						4'hB: begin branch = 1; c = ~df; end
						4'hC: skip = ie;
						4'hD: skip = q_reg;
						4'hE: skip = (d_acc == 0);
						default: skip = df;
					endcase
					if (branch) begin
						if (c) regs[p] = {w.imm_first, w.imm_second};
						else regs[p] = regs[p] + 16'd2;
					end else if (skip) regs[p] = regs[p] + 16'd2;
				end
				4'hD: psel = n;
				4'hE: xsel = n;
				default: begin
					if (n < 8) begin
						r.data_addr = regs[x]; r.mem_read = 1;
						case (n[2:0])
							3'd0: d_acc = w.mem_data;
							3'd1: d_acc = d_acc | w.mem_data;
							3'd2: d_acc = d_acc & w.mem_data;
							3'd3: d_acc = d_acc ^ w.mem_data;
							3'd4: add_carry(d_acc, w.mem_data, 1'b0);
							3'd5: add_carry(w.mem_data, ~d_acc, 1'b1);
							3'd6: begin
								r.data_addr = 0; r.mem_read = 0; df = d_acc[0];
								d_acc = {1'b0, d_acc[7:1]};
							end
							default: add_carry(d_acc, ~w.mem_data, 1'b1);
						endcase
					end else begin
						if (n != 4'hE) regs[p] = regs[p] + 16'd1;
						case (n[2:0])
							3'd0: d_acc = w.imm_first;
							3'd1: d_acc = d_acc | w.imm_first;
							3'd2: d_acc = d_acc & w.imm_first;
							3'd3: d_acc = d_acc ^ w.imm_first;
							3'd4: add_carry(d_acc, w.imm_first, 1'b0);
							3'd5: add_carry(w.imm_first, ~d_acc, 1'b1);
							3'd6: begin df = d_acc[7]; d_acc = {d_acc[6:0], 1'b0}; end
							default: add_carry(d_acc, ~w.imm_first, 1'b1);
						endcase
					end
				end
			endcase
		end
		r.next_pc = regs[psel];
		r.acc = d_acc;
		r.carry = df;
		r.q_flag = q_reg;
		r.idle = halted;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	task automatic push_row(input req_t w, input bit fixed_ok, input rsp_t f);
		step_row_t s;
		s.word = w;
		s.has_fixed = fixed_ok;
		s.fixed = f;
		directed.push_back(s);
	endtask

	function automatic req_t mk(input logic [7:0] op, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] m, input logic [7:0] pin, input logic [3:0] ef);
		req_t w;
		w.op = op; w.imm_first = a; w.imm_second = b;
		w.mem_data = m; w.port_in = pin; w.ext_flags = ef;
		return w;
	endfunction

	function automatic req_t random_word();
		req_t w;
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		w = rnd[$bits(req_t)-1:0];
		if (w.op == OpIdle) w.op = 8'hC4;
		// keep P and X mostly on low registers so branches reuse them
		if (w.op[7:4] == 4'h7 && w.op[3:1] == 3'd0 && $urandom_range(0, 3) != 0)
			w.mem_data = {2'b00, w.mem_data[5:4], 2'b00, w.mem_data[1:0]};
		return w;
	endfunction

	task automatic send_word(input req_t w);
		while (!no_idle && $urandom_range(0, 99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		expected_rsp.push_back(execute_instruction(w));
	endtask

	// result side
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("unexpected result word");
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.data_addr !== want.data_addr)
						report_mismatch("data_addr", rsp.data_addr, want.data_addr);
					if (rsp.mem_read !== want.mem_read)
						report_mismatch("mem_read", rsp.mem_read, want.mem_read);
					if (rsp.mem_write !== want.mem_write)
						report_mismatch("mem_write", rsp.mem_write, want.mem_write);
					if (rsp.write_data !== want.write_data)
						report_mismatch("write_data", rsp.write_data, want.write_data);
					if (rsp.port_strobe !== want.port_strobe)
						report_mismatch("port_strobe", rsp.port_strobe, want.port_strobe);
					if (rsp.port_num !== want.port_num)
						report_mismatch("port_num", rsp.port_num, want.port_num);
					if (rsp.next_pc !== want.next_pc)
						report_mismatch("next_pc", rsp.next_pc, want.next_pc);
					if (rsp.acc !== want.acc)
						report_mismatch("acc", rsp.acc, want.acc);
					if (rsp.carry !== want.carry)
						report_mismatch("carry", rsp.carry, want.carry);
					if (rsp.q_flag !== want.q_flag)
						report_mismatch("q_flag", rsp.q_flag, want.q_flag);
					if (rsp.cycles !== want.cycles)
						report_mismatch("cycles", rsp.cycles, want.cycles);
					if (rsp.idle !== want.idle)
						report_mismatch("idle", rsp.idle, want.idle);
				end
			end
			rsp_stall <= !no_idle && ($urandom_range(0, 99) < 14);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		rsp_t f;
		req_t w;
		int k;
		errors = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_stall = 1'b0;
		req = '0;
		for (k = 0; k < 16; k++) regs[k] = '0;
		d_acc = '0; df = 0; psel = '0; xsel = '0; t_reg = '0; q_reg = 0; ie = 1; halted = 0;

		// load immediate extremes after reset: PC 0 -> 2
		f = '0; f.cycles = CyclesShort; f.next_pc = 16'd2; f.acc = 8'hFF;
		push_row(mk(8'hF8, 8'hFF, 8'h00, 8'h00, 8'h00, 4'h0), 1, f);
		f.next_pc = 16'd4; f.acc = 8'hFE; f.carry = 1;
		push_row(mk(8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF), 1, f);
		push_row(mk(8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h6C, 8'h00, 8'h00, 8'h00, 8'hA5, 4'h0), 0, f);
		push_row(mk(8'h63, 8'h00, 8'h00, 8'h5A, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h34, 8'h10, 8'h00, 8'h00, 8'h00, 4'h1), 0, f);
		push_row(mk(8'h3F, 8'h40, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h38, 8'hFF, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'hC0, 8'hFF, 8'hFE, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'hC4, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h70, 8'h00, 8'h00, 8'h21, 8'h00, 4'h0), 0, f);
		push_row(mk(8'hCC, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h76, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'hF7, 8'h00, 8'h00, 8'h80, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'hD0, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);
		push_row(mk(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0), 0, f);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_word(directed[i].word);
			if (directed[i].has_fixed) begin
				expected_rsp.pop_back();
				expected_rsp.push_back(directed[i].fixed);
			end
		end

		for (k = 0; k < 500; k++) begin
			if (k == 150) begin
				req_valid <= 1'b0;
				while (expected_rsp.size() != 0) @(posedge clk);
			end
			no_idle = (k >= 250 && k < 330);
			w = random_word();
			send_word(w);
		end
		// idle entry near the end: everything after must echo state
		send_word(mk(OpIdle, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
		for (k = 0; k < 10; k++) send_word(random_word());
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ecs_pkg.sv
rtl/core/eight_bit_cpu_instruction_step_top.sv
bench/tb_eight_bit_cpu_instruction_step_top.sv
